### hw/rtl/dslr_pkg.sv
// Shared types and constants of the double-step line rasterizer.
package dslr_pkg;

  localparam int unsigned COORD_W   = 7;
  localparam int unsigned COLOR_W   = 8;
  localparam int unsigned COUNT_W   = 3;
  localparam int unsigned DEC_W     = 11;
  localparam int unsigned STEPS_W   = 5;
  localparam int unsigned TAIL_W    = 2;
  localparam logic [TAIL_W-1:0] TAIL_MASK = 2'h3;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = 1;
  localparam int unsigned QUEUE_CNT_W = 2;

  typedef logic [COORD_W-1:0] coord_t;

  // one line, as it arrives
  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } line_item_t;

  // one group of up to four pixels
  typedef struct packed {
    coord_t                pixel_a_x;
    coord_t                pixel_a_y;
    coord_t                pixel_b_x;
    coord_t                pixel_b_y;
    coord_t                pixel_c_x;
    coord_t                pixel_c_y;
    coord_t                pixel_d_x;
    coord_t                pixel_d_y;
    logic [COUNT_W-1:0]    pixel_count;
    logic [COLOR_W-1:0]    pixel_color;
    logic                  last_of_line;
  } pixel_group_t;

  // classified line handed from the front end to the back end
  typedef struct packed {
    logic                     is_run;     // straight run or single point
    logic                     ymaj;       // y is the major axis
    logic                     ms_neg;     // minor axis decreasing
    logic                     steep;      // slope of one half or above
    coord_t                   f_maj;
    coord_t                   f_min;
    coord_t                   b_maj;
    coord_t                   b_min;
    logic signed [DEC_W-1:0]  decision;
    logic signed [DEC_W-1:0]  threshold;
    logic signed [DEC_W-1:0]  incr1;
    logic signed [DEC_W-1:0]  incr2;
    logic [STEPS_W-1:0]       steps;
    logic [TAIL_W-1:0]        tail;
  } line_desc_t;

endpackage

### hw/rtl/dslr_front.sv
// Front end: accepts a line and classifies it into a rasterizer descriptor.
module dslr_front (
  input  dslr_pkg::line_item_t item_i,
  output dslr_pkg::line_desc_t desc_o
);

  logic                           sx, sy, ymaj, from_end, vert;
  dslr_pkg::coord_t               dx, dy, d_maj, d_min, dm1;
  dslr_pkg::coord_t               sxp, syp, exp_x, eyp;
  dslr_pkg::coord_t               lo, hi;
  logic signed [dslr_pkg::DEC_W-1:0] dmaj_w, dmin_w, incr2, thr, incr1;

  always_comb begin
    sx       = item_i.end_x < item_i.start_x;
    sy       = item_i.end_y < item_i.start_y;
    dx       = sx ? item_i.start_x - item_i.end_x : item_i.end_x - item_i.start_x;
    dy       = sy ? item_i.start_y - item_i.end_y : item_i.end_y - item_i.start_y;
    ymaj     = dy > dx;
    from_end = ymaj ? sy : sx;
    d_maj    = ymaj ? dy : dx;
    d_min    = ymaj ? dx : dy;
    sxp      = from_end ? item_i.end_x   : item_i.start_x;
    syp      = from_end ? item_i.end_y   : item_i.start_y;
    exp_x    = from_end ? item_i.start_x : item_i.end_x;
    eyp      = from_end ? item_i.start_y : item_i.end_y;

    dmaj_w = $signed({{(dslr_pkg::DEC_W-dslr_pkg::COORD_W){1'b0}}, d_maj});
    dmin_w = $signed({{(dslr_pkg::DEC_W-dslr_pkg::COORD_W){1'b0}}, d_min});
    incr2  = (dmin_w <<< 2) - (dmaj_w <<< 1);
    thr    = incr2[dslr_pkg::DEC_W-1] ? (dmin_w <<< 1) : ((dmin_w - dmaj_w) <<< 1);
    incr1  = thr <<< 1;
    dm1    = d_maj - 7'd1;

    vert = item_i.start_x == item_i.end_x;
    if (vert) begin
      lo = sy ? item_i.end_y : item_i.start_y;
      hi = sy ? item_i.start_y : item_i.end_y;
    end else begin
      lo = sx ? item_i.end_x : item_i.start_x;
      hi = sx ? item_i.start_x : item_i.end_x;
    end

    desc_o.is_run    = vert || (item_i.start_y == item_i.end_y);
    desc_o.ms_neg    = sx != sy;
    desc_o.steep     = !incr2[dslr_pkg::DEC_W-1];
    desc_o.threshold = thr;
    desc_o.incr1     = incr1;
    desc_o.incr2     = incr2;
    desc_o.decision  = incr2[dslr_pkg::DEC_W-1] ? incr1 - dmaj_w : incr1 + dmaj_w;
    desc_o.steps     = dm1[dslr_pkg::COORD_W-1:2];
    desc_o.tail      = dm1[dslr_pkg::TAIL_W-1:0] & dslr_pkg::TAIL_MASK;
    if (desc_o.is_run) begin
      desc_o.ymaj  = vert;
      desc_o.f_maj = lo;
      desc_o.b_maj = hi;
      desc_o.f_min = vert ? item_i.start_x : item_i.start_y;
      desc_o.b_min = vert ? item_i.start_x : item_i.start_y;
    end else begin
      desc_o.ymaj  = ymaj;
      desc_o.f_maj = ymaj ? syp : sxp;
      desc_o.f_min = ymaj ? sxp : syp;
      desc_o.b_maj = ymaj ? eyp : exp_x;
      desc_o.b_min = ymaj ? exp_x : eyp;
    end
  end

endmodule

### hw/rtl/dslr_queue.sv
// Short descriptor queue between the front end and the back end.
module dslr_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  dslr_pkg::line_desc_t push_data_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output dslr_pkg::line_desc_t pop_data_o
);

  dslr_pkg::line_desc_t entry_q [dslr_pkg::QUEUE_DEPTH];
  logic [dslr_pkg::QUEUE_PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [dslr_pkg::QUEUE_CNT_W-1:0] count_q, count_d;

  assign full_o     = count_q == dslr_pkg::QUEUE_CNT_W'(dslr_pkg::QUEUE_DEPTH);
  assign empty_o    = count_q == '0;
  assign pop_data_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q + dslr_pkg::QUEUE_PTR_W'(push_i);
    rd_ptr_d = rd_ptr_q + dslr_pkg::QUEUE_PTR_W'(pop_i);
    count_d  = count_q + dslr_pkg::QUEUE_CNT_W'(push_i) - dslr_pkg::QUEUE_CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### hw/rtl/dslr_back.sv
// Back end: steps through one line and emits pixel groups into an output register.
module dslr_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [dslr_pkg::COLOR_W-1:0]  pen_color_i,
  input  logic                          q_empty_i,
  input  dslr_pkg::line_desc_t          q_data_i,
  output logic                          q_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output dslr_pkg::pixel_group_t        out_item_o
);

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_RUN   = 3'd1;
  localparam logic [2:0] PH_FIRST = 3'd2;
  localparam logic [2:0] PH_STEP  = 3'd3;
  localparam logic [2:0] PH_TAIL  = 3'd4;

  localparam logic [1:0] PAT_FLAT  = 2'd0;  // offsets (0,0)
  localparam logic [1:0] PAT_LOW   = 2'd1;  // offsets (0,1)
  localparam logic [1:0] PAT_MID   = 2'd2;  // offsets (1,1)
  localparam logic [1:0] PAT_STEEP = 2'd3;  // offsets (1,2)

  logic [2:0]           phase_q, phase_d;
  dslr_pkg::line_desc_t ln_q, ln_d;
  logic                 out_valid_q, out_valid_d;
  dslr_pkg::pixel_group_t out_q, out_d;

  logic                 advance, emit, last;
  logic [1:0]           pat;
  dslr_pkg::coord_t     off1, off2, mb, rem;
  dslr_pkg::coord_t     maj [4];
  dslr_pkg::coord_t     mnr [4];
  dslr_pkg::coord_t     px  [4];
  dslr_pkg::coord_t     py  [4];
  logic [dslr_pkg::COUNT_W-1:0] cnt;

  assign advance     = !out_valid_q || !out_stall_i;
  assign emit        = advance && (phase_q != PH_IDLE);
  assign q_pop_o     = (phase_q == PH_IDLE) && !q_empty_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    // pattern choice from the running decision value
    if (!ln_q.steep) begin
      if (ln_q.decision < 0)                   pat = PAT_FLAT;
      else if (ln_q.decision < ln_q.threshold) pat = PAT_LOW;
      else                                     pat = PAT_MID;
    end else begin
      if (ln_q.decision > 0)                   pat = PAT_STEEP;
      else if (ln_q.decision < ln_q.threshold) pat = PAT_LOW;
      else                                     pat = PAT_MID;
    end
    case (pat)
      PAT_FLAT:  begin off1 = 7'd0; off2 = 7'd0; end
      PAT_LOW:   begin off1 = 7'd0; off2 = 7'd1; end
      PAT_MID:   begin off1 = 7'd1; off2 = 7'd1; end
      PAT_STEEP: begin off1 = 7'd1; off2 = 7'd2; end
      default:   begin off1 = 7'd0; off2 = 7'd0; end
    endcase
    // backward tail pixel: steep branch with the middle pattern steps only past c
    mb = off1;
    if (ln_q.steep && (pat == PAT_MID) && !(ln_q.decision > ln_q.threshold)) begin
      mb = 7'd0;
    end

    rem     = ln_q.b_maj - ln_q.f_maj;
    ln_d    = ln_q;
    phase_d = phase_q;
    last    = 1'b0;
    cnt     = 3'd0;
    for (int i = 0; i < 4; i++) begin
      maj[i] = '0;
      mnr[i] = '0;
    end

    case (phase_q)
      PH_IDLE: begin
        if (!q_empty_i) begin
          ln_d    = q_data_i;
          phase_d = q_data_i.is_run ? PH_RUN : PH_FIRST;
        end
      end
      PH_RUN: begin
        cnt  = (rem >= 7'd3) ? 3'd4 : dslr_pkg::COUNT_W'(rem + 7'd1);
        last = rem <= 7'd3;
        for (int i = 0; i < 4; i++) begin
          maj[i] = ln_q.f_maj + 7'(i);
          mnr[i] = ln_q.f_min;
        end
        if (emit) begin
          ln_d.f_maj = ln_q.f_maj + 7'd4;
          if (last) phase_d = PH_IDLE;
        end
      end
      PH_FIRST: begin
        cnt    = 3'd2;
        last   = (ln_q.steps == '0) && (ln_q.tail == '0);
        maj[0] = ln_q.f_maj;
        mnr[0] = ln_q.f_min;
        maj[1] = ln_q.b_maj;
        mnr[1] = ln_q.b_min;
        if (emit) begin
          if (last)                    phase_d = PH_IDLE;
          else if (ln_q.steps != '0)   phase_d = PH_STEP;
          else                         phase_d = PH_TAIL;
        end
      end
      PH_STEP: begin
        cnt    = 3'd4;
        last   = (ln_q.steps == 5'd1) && (ln_q.tail == '0);
        maj[0] = ln_q.f_maj + 7'd1;
        mnr[0] = ln_q.ms_neg ? ln_q.f_min - off1 : ln_q.f_min + off1;
        maj[1] = ln_q.f_maj + 7'd2;
        mnr[1] = ln_q.ms_neg ? ln_q.f_min - off2 : ln_q.f_min + off2;
        maj[2] = ln_q.b_maj - 7'd1;
        mnr[2] = ln_q.ms_neg ? ln_q.b_min + off1 : ln_q.b_min - off1;
        maj[3] = ln_q.b_maj - 7'd2;
        mnr[3] = ln_q.ms_neg ? ln_q.b_min + off2 : ln_q.b_min - off2;
        if (emit) begin
          ln_d.f_maj    = maj[1];
          ln_d.f_min    = mnr[1];
          ln_d.b_maj    = maj[3];
          ln_d.b_min    = mnr[3];
          ln_d.decision = ln_q.decision +
                          (((pat == PAT_FLAT) || (pat == PAT_STEEP)) ? ln_q.incr1 : ln_q.incr2);
          ln_d.steps    = ln_q.steps - 5'd1;
          if (ln_q.steps == 5'd1) begin
            phase_d = (ln_q.tail == '0) ? PH_IDLE : PH_TAIL;
          end
        end
      end
      PH_TAIL: begin
        cnt    = {1'b0, ln_q.tail};
        last   = 1'b1;
        maj[0] = ln_q.f_maj + 7'd1;
        mnr[0] = ln_q.ms_neg ? ln_q.f_min - off1 : ln_q.f_min + off1;
        maj[1] = ln_q.f_maj + 7'd2;
        mnr[1] = ln_q.ms_neg ? ln_q.f_min - off2 : ln_q.f_min + off2;
        maj[2] = ln_q.b_maj - 7'd1;
        mnr[2] = ln_q.ms_neg ? ln_q.b_min + mb : ln_q.b_min - mb;
        if (emit) phase_d = PH_IDLE;
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase

    // axis mapping and zeroing of unused slots
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < cnt) begin
        px[i] = ln_q.ymaj ? mnr[i] : maj[i];
        py[i] = ln_q.ymaj ? maj[i] : mnr[i];
      end else begin
        px[i] = '0;
        py[i] = '0;
      end
    end

    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (advance) begin
      out_valid_d = emit;
    end
    if (emit) begin
      out_d.pixel_a_x    = px[0];
      out_d.pixel_a_y    = py[0];
      out_d.pixel_b_x    = px[1];
      out_d.pixel_b_y    = py[1];
      out_d.pixel_c_x    = px[2];
      out_d.pixel_c_y    = py[2];
      out_d.pixel_d_x    = px[3];
      out_d.pixel_d_y    = py[3];
      out_d.pixel_count  = cnt;
      out_d.pixel_color  = pen_color_i;
      out_d.last_of_line = last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ln_q  <= ln_d;
    out_q <= out_d;
  end

endmodule

### hw/rtl/double_step_line_rasterizer_unit.sv
// Top level of the double-step line rasterizer.
//
// Usage:
//   in channel  : one transaction is one line (two endpoints, 7-bit coords),
//                 taken when in_valid_i is high and in_stall_o is low.
//   out channel : one transaction is a group of 1 to 4 pixels plus the pen
//                 color; last_of_line marks the final group of a line.
//   cfg channel : writes pen_color, taken on cfg_valid_i && cfg_ready_o.
// A taken line passes the descriptor queue and the back end's line register
//   before its first group reaches the output register. A line has at most
//   33 groups; after a load state the stepping sequencer gives one per cycle
//   unless stalled, and the two-entry descriptor queue takes lines meanwhile.
// Reset clears the queue, the sequencer and the output valid; pen color
//   resets to zero.
// When out_stall_i is high while a group is held, it stays put and stepping
//   pauses; in_stall_o rises only once the descriptor queue is full.
module double_step_line_rasterizer_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  dslr_pkg::line_item_t         in_item_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output dslr_pkg::pixel_group_t       out_item_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [dslr_pkg::COLOR_W-1:0] cfg_data_i
);

  logic [dslr_pkg::COLOR_W-1:0] pen_color_q;
  dslr_pkg::line_desc_t         front_desc, q_desc;
  logic                         q_full, q_empty, q_pop, q_push;

  // pen color register; always ready; to be written only between lines, which the block does not enforce
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_color_q <= '0;
    end else if (cfg_valid_i) begin
      pen_color_q <= cfg_data_i;
    end
  end

  // front end: classify line (run or slanted) and derive its step setup
  dslr_front u_front (
    .item_i (in_item_i),
    .desc_o (front_desc)
  );

  assign in_stall_o = q_full;
  assign q_push     = in_valid_i && !q_full;

  dslr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (front_desc),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_data_o  (q_desc)
  );

  // back end: one pixel group per cycle into the output register while not stalled
  dslr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pen_color_i (pen_color_q),
    .q_empty_i   (q_empty),
    .q_data_i    (q_desc),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

### tb/sv/dslr_line_checker.sv
// Checker for the line rasterizer: predicts each line's pixel groups and compares the output.
module dslr_line_checker
  import dslr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  line_item_t         in_item_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  pixel_group_t       out_item_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [COLOR_W-1:0] cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 groups_checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // two-pixel step patterns, by minor offset at major +1 / +2
  typedef enum int {
    PAT_FLAT   = 1,  // (0,0)
    PAT_LATE   = 2,  // (0,1)
    PAT_EARLY  = 3,  // (1,1)
    PAT_DOUBLE = 4   // (1,2)
  } step_pattern_e;

  logic [COLOR_W-1:0] pen_color_q;
  int                 decision_q;
  int                 threshold_q;
  int                 incr_one_q;
  int                 incr_two_q;

  pixel_group_t       expected_groups[$];
  coord_t             grp_x[4];
  coord_t             grp_y[4];
  int                 grp_n;
  int                 fail_count = 0;
  int                 groups_checked = 0;

  function automatic step_pattern_e pick_pattern(bit steep);
    if (!steep) begin
      if (decision_q < 0) return PAT_FLAT;
      return (decision_q < threshold_q) ? PAT_LATE : PAT_EARLY;
    end
    if (decision_q > 0) return PAT_DOUBLE;
    return (decision_q < threshold_q) ? PAT_LATE : PAT_EARLY;
  endfunction

  function automatic int near_offset(step_pattern_e p);
    return (p >= PAT_EARLY) ? 1 : 0;
  endfunction

  function automatic int far_offset(step_pattern_e p);
    case (p)
      PAT_FLAT:   return 0;
      PAT_DOUBLE: return 2;
      default:    return 1;
    endcase
  endfunction

  function automatic void grp_clear();
    grp_n = 0;
    for (int i = 0; i < 4; i++) begin
      grp_x[i] = '0;
      grp_y[i] = '0;
    end
  endfunction

  function automatic void grp_add(bit ymaj, int maj, int mnr);
    if (grp_n < 4) begin
      grp_x[grp_n] = coord_t'(ymaj ? mnr : maj);
      grp_y[grp_n] = coord_t'(ymaj ? maj : mnr);
      grp_n++;
    end
  endfunction

  function automatic void grp_push();
    pixel_group_t g;
    g.pixel_a_x    = grp_x[0];
    g.pixel_a_y    = grp_y[0];
    g.pixel_b_x    = grp_x[1];
    g.pixel_b_y    = grp_y[1];
    g.pixel_c_x    = grp_x[2];
    g.pixel_c_y    = grp_y[2];
    g.pixel_d_x    = grp_x[3];
    g.pixel_d_y    = grp_y[3];
    g.pixel_count  = COUNT_W'(grp_n);
    g.pixel_color  = pen_color_q;
    g.last_of_line = 1'b0;
    expected_groups.push_back(g);
  endfunction

  // Queues every group the line should produce.
  function automatic void predict_line(line_item_t ln);
    int            a1, b1, a2, b2, lo, hi, v;
    int            dx, dy, d_maj, d_min, ms, mb, steps, tail;
    int            fwd_maj, fwd_min, bwd_maj, bwd_min;
    bit            vert, sx, sy, ymaj, from_end, steep;
    step_pattern_e pat;
    pixel_group_t  g;
    a1 = int'(ln.start_x);
    b1 = int'(ln.start_y);
    a2 = int'(ln.end_x);
    b2 = int'(ln.end_y);
    if (a1 == a2 || b1 == b2) begin
      // straight run or single point, ascending, up to four per group
      vert = (a1 == a2);
      lo = vert ? ((b1 < b2) ? b1 : b2) : ((a1 < a2) ? a1 : a2);
      hi = vert ? ((b1 < b2) ? b2 : b1) : ((a1 < a2) ? a2 : a1);
      v = lo;
      while (v <= hi) begin
        grp_clear();
        while (grp_n < 4 && v <= hi) begin
          grp_add(vert, v, vert ? a1 : b1);
          v++;
        end
        grp_push();
      end
    end else begin
      sx = a2 < a1;
      sy = b2 < b1;
      dx = sx ? a1 - a2 : a2 - a1;
      dy = sy ? b1 - b2 : b2 - b1;
      ymaj = dy > dx;
      from_end = ymaj ? sy : sx;
      ms = (sx == sy) ? 1 : -1;
      d_maj = ymaj ? dy : dx;
      d_min = ymaj ? dx : dy;
      fwd_maj = ymaj ? (from_end ? b2 : b1) : (from_end ? a2 : a1);
      fwd_min = ymaj ? (from_end ? a2 : a1) : (from_end ? b2 : b1);
      bwd_maj = ymaj ? (from_end ? b1 : b2) : (from_end ? a1 : a2);
      bwd_min = ymaj ? (from_end ? a1 : a2) : (from_end ? b1 : b2);

      incr_two_q  = 4 * d_min - 2 * d_maj;
      steep       = incr_two_q >= 0;
      threshold_q = steep ? 2 * (d_min - d_maj) : 2 * d_min;
      incr_one_q  = 2 * threshold_q;
      decision_q  = steep ? incr_one_q + d_maj : incr_one_q - d_maj;
      steps = (d_maj - 1) >>> 2;
      tail  = (d_maj - 1) & int'(TAIL_MASK);

      // both endpoints first
      grp_clear();
      grp_add(ymaj, fwd_maj, fwd_min);
      grp_add(ymaj, bwd_maj, bwd_min);
      grp_push();

      while (steps > 0) begin
        pat = pick_pattern(steep);
        grp_clear();
        grp_add(ymaj, fwd_maj + 1, fwd_min + near_offset(pat) * ms);
        grp_add(ymaj, fwd_maj + 2, fwd_min + far_offset(pat) * ms);
        grp_add(ymaj, bwd_maj - 1, bwd_min - near_offset(pat) * ms);
        grp_add(ymaj, bwd_maj - 2, bwd_min - far_offset(pat) * ms);
        grp_push();
        fwd_maj += 2;
        fwd_min += far_offset(pat) * ms;
        bwd_maj -= 2;
        bwd_min -= far_offset(pat) * ms;
        decision_q += (pat == PAT_FLAT || pat == PAT_DOUBLE) ? incr_one_q : incr_two_q;
        steps--;
      end

      if (tail != 0) begin
        pat = pick_pattern(steep);
        mb = (pat >= PAT_EARLY) ? 1 : 0;
        if (steep && pat == PAT_EARLY && !(decision_q > threshold_q)) mb = 0;
        grp_clear();
        grp_add(ymaj, fwd_maj + 1, fwd_min + near_offset(pat) * ms);
        if (tail > 1) grp_add(ymaj, fwd_maj + 2, fwd_min + far_offset(pat) * ms);
        if (tail > 2) grp_add(ymaj, bwd_maj - 1, bwd_min - mb * ms);
        grp_push();
      end
    end
    g = expected_groups.pop_back();
    g.last_of_line = 1'b1;
    expected_groups.push_back(g);
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    pixel_group_t want;
    if (!rst_ni) begin
      pen_color_q = '0;
      decision_q  = 0;
      threshold_q = 0;
      incr_one_q  = 0;
      incr_two_q  = 0;
      expected_groups.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) pen_color_q = cfg_data_i;
      if (in_valid_i && !in_stall_i) predict_line(in_item_i);
      if (out_valid_i && !out_stall_i) begin
        if (expected_groups.size() == 0) begin
          $error("output transaction with no pixel group expected");
          fail_count++;
        end else begin
          want = expected_groups.pop_front();
          check_field("pixel_a_x", want.pixel_a_x, out_item_i.pixel_a_x);
          check_field("pixel_a_y", want.pixel_a_y, out_item_i.pixel_a_y);
          check_field("pixel_b_x", want.pixel_b_x, out_item_i.pixel_b_x);
          check_field("pixel_b_y", want.pixel_b_y, out_item_i.pixel_b_y);
          check_field("pixel_c_x", want.pixel_c_x, out_item_i.pixel_c_x);
          check_field("pixel_c_y", want.pixel_c_y, out_item_i.pixel_c_y);
          check_field("pixel_d_x", want.pixel_d_x, out_item_i.pixel_d_x);
          check_field("pixel_d_y", want.pixel_d_y, out_item_i.pixel_d_y);
          check_field("pixel_count", want.pixel_count, out_item_i.pixel_count);
          check_field("pixel_color", want.pixel_color, out_item_i.pixel_color);
          check_field("last_of_line", want.last_of_line, out_item_i.last_of_line);
          groups_checked++;
        end
      end
    end
    // published with NBAs so readers at the same edge see settled values
    fail_count_o     <= fail_count;
    pending_o        <= expected_groups.size();
    groups_checked_o <= groups_checked;
  end

endmodule

### tb/sv/tb_double_step_line_rasterizer_unit.sv
// Testbench top for the double-step line rasterizer: stimulus, watchdog and verdict.
module tb_double_step_line_rasterizer_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import dslr_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transaction on any channel
  localparam int DRAIN_CYCLES   = 8;     // settling time after the last drain, before the verdict
  localparam int IDLE_PCT       = 9;
  localparam int PHASE_LINES    = 97;
  localparam int NUM_PHASES     = 4;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  line_item_t         in_item_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  pixel_group_t       out_item_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [COLOR_W-1:0] cfg_data_i  = '0;

  int fail_count;
  int pending;
  int groups_checked;

  // quiet = 1 turns off idling on both sides for one long stretch
  bit quiet = 1'b0;
  int lines_sent = 0;
  int colors_written = 0;

  double_step_line_rasterizer_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  dslr_line_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .in_item_i        (in_item_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_item_i       (out_item_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .groups_checked_o (groups_checked)
  );

  // 2 ns clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Receiver back-pressure: random stalls, changed only at the falling edge.
  always @(negedge clk_i) begin
    out_stall_i <= quiet ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
  end

  // Watchdog: any accepted transaction on any channel restarts the count.
  initial begin : watchdog
    int idle_run;
    idle_run = 0;
    while (idle_run < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        idle_run = 0;
      else
        idle_run++;
    end
    $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  function automatic line_item_t mk_line(int sx, int sy, int ex, int ey);
    line_item_t ln;
    ln.start_x = coord_t'(sx);
    ln.start_y = coord_t'(sy);
    ln.end_x   = coord_t'(ex);
    ln.end_y   = coord_t'(ey);
    return ln;
  endfunction

  // c moved by d in a random direction, staying on the 0..127 grid
  function automatic coord_t near_coord(coord_t c, int d);
    if ($urandom_range(1) && int'(c) >= d) return coord_t'(int'(c) - d);
    if (int'(c) + d <= 127) return coord_t'(int'(c) + d);
    return coord_t'(int'(c) - d);
  endfunction

  // Mix of runs, points, short lines (all tail lengths), slope-boundary lines
  // and fully random endpoints.
  function automatic line_item_t random_line();
    line_item_t ln;
    int         kind, dmaj, dmin;
    bit         xmaj;
    kind = $urandom_range(99);
    ln.start_x = coord_t'($urandom);
    ln.start_y = coord_t'($urandom);
    ln.end_x   = coord_t'($urandom);
    ln.end_y   = coord_t'($urandom);
    if (kind < 12) begin
      ln.end_y = ln.start_y;
    end else if (kind < 24) begin
      ln.end_x = ln.start_x;
    end else if (kind < 28) begin
      ln.end_x = ln.start_x;
      ln.end_y = ln.start_y;
    end else if (kind < 60) begin
      ln.end_x = near_coord(ln.start_x, $urandom_range(1, 9));
      ln.end_y = near_coord(ln.start_y, $urandom_range(1, 9));
    end else if (kind < 72) begin
      // around slope one half (branch switch) and slope one (axis tie)
      dmaj = $urandom_range(2, 60);
      case ($urandom_range(2))
        0:       dmin = dmaj / 2;
        1:       dmin = dmaj / 2 + 1;
        default: dmin = dmaj;
      endcase
      xmaj = $urandom_range(1);
      ln.end_x = near_coord(ln.start_x, xmaj ? dmaj : dmin);
      ln.end_y = near_coord(ln.start_y, xmaj ? dmin : dmaj);
    end
    return ln;
  endfunction

  // One line transaction; valid stays high into the next call unless it idles.
  task automatic draw_line(input line_item_t ln);
    @(negedge clk_i);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_item_i  = ln;
    do @(posedge clk_i); while (in_stall_o);
    lines_sent++;
  endtask

  // Ends a burst and holds off until every predicted group has come out.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending != 0) @(posedge clk_i);
  endtask

  // pen_color write; only called with the block idle
  task automatic write_pen_color(input logic [COLOR_W-1:0] color);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = color;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    colors_written++;
  endtask

  initial begin : stimulus
    logic [COLOR_W-1:0] color;
    // reset asserted, then released on a falling edge
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed lines under the brightest pen.
    write_pen_color(8'hFF);
    draw_line(mk_line(0, 0, 0, 0));          // single point, low corner
    draw_line(mk_line(127, 127, 127, 127));  // single point, high corner
    draw_line(mk_line(0, 5, 127, 5));        // full horizontal run
    draw_line(mk_line(127, 9, 0, 9));        // horizontal, given right to left
    draw_line(mk_line(3, 0, 3, 127));        // full vertical run
    draw_line(mk_line(120, 127, 120, 0));    // vertical, given top down
    draw_line(mk_line(0, 0, 127, 127));      // diagonal, axis tie goes to x
    draw_line(mk_line(127, 0, 0, 127));      // diagonal, minor axis decreasing
    draw_line(mk_line(0, 0, 127, 10));       // long shallow x-major
    draw_line(mk_line(0, 0, 127, 100));      // long x-major, steep branch
    draw_line(mk_line(10, 0, 20, 127));      // y-major, shallow branch
    draw_line(mk_line(100, 127, 0, 0));      // y-major, steep, from far end
    draw_line(mk_line(10, 10, 11, 11));      // one major step: endpoints only
    draw_line(mk_line(10, 10, 12, 11));      // one tail pixel
    draw_line(mk_line(10, 10, 13, 11));      // two tail pixels
    draw_line(mk_line(10, 10, 14, 12));      // three tail pixels
    draw_line(mk_line(10, 10, 15, 11));      // one double step, no tail
    draw_line(mk_line(0, 0, 7, 5));          // steep branch with a two-pixel tail
    draw_line(mk_line(0, 0, 11, 7));
    draw_line(mk_line(20, 30, 13, 25));      // tail, given from the far end
    draw_line(mk_line(127, 0, 120, 6));
    draw_line(mk_line(64, 64, 63, 0));       // near-vertical, x moves once
    drain();

    // Random lines, one pen color per phase; phase 2 runs with no idling.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       color = 8'h00;
        1:       color = COLOR_W'($urandom);
        2:       color = 8'h5A;
        default: color = 8'hA5;
      endcase
      write_pen_color(color);
      quiet = (ph == 2);
      for (int i = 0; i < PHASE_LINES; i++) draw_line(random_line());
      drain();
    end
    quiet = 1'b0;

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Drew %0d lines under %0d pen colors; %0d pixel groups compared.",
             lines_sent, colors_written, groups_checked);
    $display("Covered runs, points, both slope branches, all tails and reversed ends.");
    if (fail_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

### double_step_line_rasterizer_unit.f
hw/rtl/dslr_pkg.sv
hw/rtl/dslr_front.sv
hw/rtl/dslr_queue.sv
hw/rtl/dslr_back.sv
hw/rtl/double_step_line_rasterizer_unit.sv
tb/sv/dslr_line_checker.sv
tb/sv/tb_double_step_line_rasterizer_unit.sv
